### hdl/oaht_pkg.sv
// Shared constants, codes and controller/datapath interface types for the hash table unit.
package oaht_pkg;

  localparam int MAX_SLOTS    = 128;
  localparam int PROBE_FACTOR = 100;

  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int SIZE_W     = $clog2(MAX_SLOTS + 1);
  localparam int CNT_W      = $clog2(MAX_SLOTS * PROBE_FACTOR + 1);
  localparam int KEY_W      = 31;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int ADDR_OUT_W = 7;
  localparam int CFG_SIZE_W = 8;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int KEY_PAD_W  = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DELETED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DEL_MISSING = 3'd6;

  localparam logic REG_PROBE_MODE = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                rd;
    logic                advance;
    logic                wr_ins;
    logic                wr_del;
    logic                out_load;
    logic                use_pos;
    logic [STATUS_W-1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            trivial;
    logic            div_last;
    logic            hit_empty;
    logic            hit_match;
    logic            hit_del;
    logic            probe_last;
    logic            out_free;
  } stat_t;

endpackage

### hdl/oaht_ctrl.sv
// Request sequencer: hashing, probe read/check loop and result hand-off.
module oaht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  oaht_pkg::stat_t stat,
  output oaht_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]                    state, state_next;
  logic [oaht_pkg::STATUS_W-1:0] res_code, res_code_next;
  logic                          use_pos, use_pos_next;
  logic                          is_insert;

  assign is_insert = (stat.op == oaht_pkg::OP_INSERT);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    use_pos_next  = use_pos;
    cmd           = '0;
    cmd.res_code  = res_code;
    cmd.use_pos   = use_pos;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          use_pos_next = 1'b0;
          if (stat.trivial) begin
            unique case (stat.op)
              oaht_pkg::OP_INSERT: res_code_next = oaht_pkg::ST_FULL;
              oaht_pkg::OP_DELETE: res_code_next = oaht_pkg::ST_DEL_MISSING;
              default:             res_code_next = oaht_pkg::ST_NOT_FOUND;
            endcase
            state_next = S_RESP;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (is_insert) begin
          priority if (stat.hit_empty) begin
            cmd.wr_ins    = 1'b1;
            res_code_next = oaht_pkg::ST_INSERTED;
            use_pos_next  = 1'b1;
            state_next    = S_RESP;
          end else if (stat.hit_match) begin
            res_code_next = oaht_pkg::ST_DUPLICATE;
            use_pos_next  = 1'b1;
            state_next    = S_RESP;
          end else if (stat.probe_last) begin
            res_code_next = oaht_pkg::ST_FULL;
            state_next    = S_RESP;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end else begin
          priority if (!stat.hit_del && stat.hit_empty) begin
            res_code_next = (stat.op == oaht_pkg::OP_DELETE) ? oaht_pkg::ST_DEL_MISSING
                                                              : oaht_pkg::ST_NOT_FOUND;
            state_next    = S_RESP;
          end else if (!stat.hit_del && stat.hit_match) begin
            if (stat.op == oaht_pkg::OP_DELETE) begin
              cmd.wr_del    = 1'b1;
              res_code_next = oaht_pkg::ST_DELETED;
            end else begin
              res_code_next = oaht_pkg::ST_FOUND;
            end
            state_next = S_RESP;
          end else if (stat.probe_last) begin
            res_code_next = (stat.op == oaht_pkg::OP_DELETE) ? oaht_pkg::ST_DEL_MISSING
                                                              : oaht_pkg::ST_NOT_FOUND;
            state_next    = S_RESP;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res_code <= res_code_next;
    use_pos  <= use_pos_next;
  end

endmodule

### hdl/oaht_dp.sv
// Datapath: key remainder unit, probe offset generator, slot memory and result register.
module oaht_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                probe_mode,
  input  logic [oaht_pkg::CFG_SIZE_W-1:0]     table_size,
  input  logic [oaht_pkg::OP_W-1:0]           opcode,
  input  logic [oaht_pkg::KEY_W-1:0]          key,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [oaht_pkg::STATUS_W-1:0]       status,
  output logic [oaht_pkg::ADDR_OUT_W-1:0]     slot_address,
  input  oaht_pkg::cmd_t                      cmd,
  output oaht_pkg::stat_t                     stat
);

  localparam int SW = oaht_pkg::SIZE_W;
  localparam int AW = oaht_pkg::SLOT_W;
  localparam int KW = oaht_pkg::KEY_W;

  logic [oaht_pkg::OP_W-1:0]      op_r;
  logic [KW-1:0]                  key_r;
  logic [oaht_pkg::KEY_PAD_W-1:0] key_sh;
  logic [SW-1:0]                  rem, rem_next;
  logic [oaht_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [SW-1:0]                  size_r, eff_size;
  logic                           mode_r;
  logic [SW-1:0]                  off, off_next, dinc, dinc_next, dinc_init;
  logic [AW-1:0]                  pos, addr;
  logic [oaht_pkg::CNT_W-1:0]     remain, limit;
  logic [KW:0]                    rd_word, wr_word;
  logic                           rd_vld;
  logic [oaht_pkg::MAX_SLOTS-1:0] vld;
  logic [KW:0]                    mem [oaht_pkg::MAX_SLOTS];
  logic                           wr;
  logic [KW-1:0]                  key_eff;

  // effective size: zero acts as one, oversize clamps
  always_comb begin
    if (table_size == '0) begin
      eff_size = SW'(1);
    end else if (int'(table_size) > oaht_pkg::MAX_SLOTS) begin
      eff_size = SW'(oaht_pkg::MAX_SLOTS);
    end else begin
      eff_size = SW'(table_size);
    end
  end

  assign dinc_init = (eff_size == SW'(1)) ? '0 : SW'(1);
  assign limit     = oaht_pkg::CNT_W'(eff_size) * oaht_pkg::CNT_W'(oaht_pkg::PROBE_FACTOR);

  // remainder, DIV_BITS key bits per cycle
  always_comb begin
    logic [SW:0] r;
    r = {1'b0, rem};
    for (int k = 0; k < oaht_pkg::DIV_BITS; k++) begin
      r = {r[SW-1:0], key_sh[oaht_pkg::KEY_PAD_W-1-k]};
      if (r >= {1'b0, size_r}) begin
        r = r - {1'b0, size_r};
      end
    end
    rem_next = r[SW-1:0];
  end

  // slot = (home + offset) mod size
  always_comb begin
    logic [SW:0] a;
    a = {1'b0, rem} + {1'b0, off};
    if (a >= {1'b0, size_r}) begin
      a = a - {1'b0, size_r};
    end
    addr = a[AW-1:0];
  end

  // next offset: i mod size, or i*i mod size by adding (2i+1) mod size
  always_comb begin
    logic [SW:0] t;
    logic [SW:0] d;
    d = {1'b0, dinc} + (SW+1)'(2);
    if (d >= {1'b0, size_r}) begin
      d = d - {1'b0, size_r};
    end
    if (d >= {1'b0, size_r}) begin
      d = d - {1'b0, size_r};
    end
    dinc_next = d[SW-1:0];
    if (mode_r) begin
      t = {1'b0, off} + {1'b0, dinc};
    end else begin
      t = {1'b0, off} + (SW+1)'(1);
    end
    if (t >= {1'b0, size_r}) begin
      t = t - {1'b0, size_r};
    end
    off_next = t[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode;
      key_r   <= key;
      key_sh  <= oaht_pkg::KEY_PAD_W'(key);
      rem     <= '0;
      div_cnt <= oaht_pkg::DIV_CNT_W'(oaht_pkg::DIV_STEPS - 1);
      size_r  <= eff_size;
      mode_r  <= probe_mode;
      off     <= '0;
      dinc    <= dinc_init;
      remain  <= limit;
    end else begin
      if (cmd.div_step) begin
        key_sh  <= key_sh << oaht_pkg::DIV_BITS;
        rem     <= rem_next;
        div_cnt <= div_cnt - oaht_pkg::DIV_CNT_W'(1);
      end
      if (cmd.advance) begin
        off    <= off_next;
        dinc   <= dinc_next;
        remain <= remain - oaht_pkg::CNT_W'(1);
      end
    end
  end

  assign wr      = cmd.wr_ins | cmd.wr_del;
  assign wr_word = cmd.wr_del ? {1'b1, {KW{1'b0}}} : {1'b0, key_r};

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[pos] <= wr_word;
    end
    if (cmd.rd) begin
      rd_word <= mem[addr];
      rd_vld  <= vld[addr];
      pos     <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr) begin
      vld[pos] <= 1'b1;
    end
  end

  assign key_eff = rd_vld ? rd_word[KW-1:0] : '0;

  assign stat.op         = op_r;
  assign stat.trivial    = (op_r == oaht_pkg::OP_NONE) || (key_r == '0);
  assign stat.div_last   = (div_cnt == '0);
  assign stat.hit_empty  = (key_eff == '0);
  assign stat.hit_match  = (key_eff == key_r);
  assign stat.hit_del    = rd_vld & rd_word[KW];
  assign stat.probe_last = (remain == oaht_pkg::CNT_W'(1));
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= cmd.res_code;
      slot_address <= cmd.use_pos ? oaht_pkg::ADDR_OUT_W'(pos) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hdl/open_addressing_hash_table_unit.sv
// Top level of the open-addressing hash table: APB registers, controller and datapath.
//
// One request (insert, find or delete) is taken at a time. After the transfer the key
// remainder unit forms the home slot, then each probe is a registered read of the slot
// memory followed by the compare and optional write, and then the result register is
// loaded. A request makes at most 100 times the table size probes. Opcode 3 and key 0
// make no probe. The slot store comes out of reset empty at once through per-slot valid
// flops; no clearing pass is needed. The next request is taken while a finished result
// still waits on the output.
module open_addressing_hash_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [oaht_pkg::PADDR_W-1:0]    paddr,
  input  logic [oaht_pkg::DATA_W-1:0]     pwdata,
  output logic [oaht_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [oaht_pkg::OP_W-1:0]       opcode,
  input  logic [oaht_pkg::KEY_W-1:0]      key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [oaht_pkg::STATUS_W-1:0]   status,
  output logic [oaht_pkg::ADDR_OUT_W-1:0] slot_address
);

  logic                            probe_mode;
  logic [oaht_pkg::CFG_SIZE_W-1:0] table_size;
  logic                            reg_sel;
  oaht_pkg::cmd_t                  cmd;
  oaht_pkg::stat_t                 stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode <= 1'b0;
      table_size <= oaht_pkg::CFG_SIZE_W'(oaht_pkg::MAX_SLOTS);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        oaht_pkg::REG_PROBE_MODE: probe_mode <= pwdata[0];
        oaht_pkg::REG_TABLE_SIZE: table_size <= pwdata[oaht_pkg::CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      oaht_pkg::REG_PROBE_MODE: prdata = oaht_pkg::DATA_W'(probe_mode);
      oaht_pkg::REG_TABLE_SIZE: prdata = oaht_pkg::DATA_W'(table_size);
      default:                  prdata = '0;
    endcase
  end

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oaht_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .probe_mode   (probe_mode),
    .table_size   (table_size),
    .opcode       (opcode),
    .key          (key),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .slot_address (slot_address),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

### dv/tb_open_addressing_hash_table_unit.sv
// Testbench for the open-addressing hash table unit with a slot-level predictor.
`timescale 1ns / 1ps

module tb_open_addressing_hash_table_unit;

  typedef struct {
    logic [oaht_pkg::OP_W-1:0]  op;
    logic [oaht_pkg::KEY_W-1:0] key;
  } request_t;

  typedef struct {
    logic [oaht_pkg::STATUS_W-1:0]   status;
    logic [oaht_pkg::ADDR_OUT_W-1:0] slot;
  } reply_t;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [oaht_pkg::PADDR_W-1:0]    paddr;
  logic [oaht_pkg::DATA_W-1:0]     pwdata;
  logic [oaht_pkg::DATA_W-1:0]     prdata;
  logic                            pready;
  logic                            in_valid;
  logic                            in_ready;
  logic [oaht_pkg::OP_W-1:0]       opcode;
  logic [oaht_pkg::KEY_W-1:0]      key;
  logic                            out_valid;
  logic                            out_ready;
  logic [oaht_pkg::STATUS_W-1:0]   status;
  logic [oaht_pkg::ADDR_OUT_W-1:0] slot_address;

  open_addressing_hash_table_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .key          (key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot_address (slot_address)
  );

  logic [oaht_pkg::KEY_W-1:0] slot_key [oaht_pkg::MAX_SLOTS] = '{default: '0};
  bit                         slot_gone [oaht_pkg::MAX_SLOTS] = '{default: 1'b0};
  bit                         quad_mode;
  logic [7:0]                 size_reg;

  request_t                   req_backlog [$];
  reply_t                     reply_due [$];
  logic [oaht_pkg::KEY_W-1:0] key_pool [$];

  bit          in_took;
  int          send_gap_pct;
  int          recv_stall_pct;
  int          n_sent;
  int          n_done = 0;
  int          n_random;
  int          mismatches = 0;
  longint      cycle_cnt = 0;
  longint      cycle_limit = 200000;

  function automatic void hash_request(input logic [oaht_pkg::OP_W-1:0] op,
                                       input logic [oaht_pkg::KEY_W-1:0] k,
                                       output logic [oaht_pkg::STATUS_W-1:0] st,
                                       output logic [oaht_pkg::ADDR_OUT_W-1:0] sa,
                                       output int unsigned probes);
    int unsigned     n;
    int unsigned     home;
    int unsigned     idx;
    int unsigned     i;
    longint unsigned off;
    bit              hit;
    n = (size_reg == 8'd0) ? 32'd1
      : (int'(size_reg) > oaht_pkg::MAX_SLOTS) ? 32'(oaht_pkg::MAX_SLOTS)
      : 32'(size_reg);
    home = 32'(k) % n;
    st = oaht_pkg::ST_NOT_FOUND;
    sa = '0;
    probes = 0;
    hit = 0;
    if (op == oaht_pkg::OP_INSERT) st = oaht_pkg::ST_FULL;
    else if (op == oaht_pkg::OP_DELETE) st = oaht_pkg::ST_DEL_MISSING;
    if (k != '0 && op != oaht_pkg::OP_NONE) begin
      for (i = 0; i < n * oaht_pkg::PROBE_FACTOR && !hit; i++) begin
        off = quad_mode ? 64'(i) * 64'(i) : 64'(i);
        idx = 32'((64'(home) + off % 64'(n)) % 64'(n));
        probes++;
        if (op == oaht_pkg::OP_INSERT) begin
          if (slot_key[idx] == '0) begin
            slot_key[idx] = k;
            slot_gone[idx] = 0;
            st = oaht_pkg::ST_INSERTED;
            sa = oaht_pkg::ADDR_OUT_W'(idx);
            hit = 1;
          end else if (slot_key[idx] == k) begin
            st = oaht_pkg::ST_DUPLICATE;
            sa = oaht_pkg::ADDR_OUT_W'(idx);
            hit = 1;
          end
        end else if (!slot_gone[idx]) begin
          if (slot_key[idx] == k) begin
            hit = 1;
            st = (op == oaht_pkg::OP_FIND) ? oaht_pkg::ST_FOUND : oaht_pkg::ST_DELETED;
            if (op == oaht_pkg::OP_DELETE) begin
              slot_key[idx] = '0;
              slot_gone[idx] = 1;
            end
          end else if (slot_key[idx] == '0) begin
            break;
          end
        end
      end
    end
  endfunction

  function automatic logic [oaht_pkg::KEY_W-1:0] rand_key();
    if ($urandom_range(4) == 0) return oaht_pkg::KEY_W'($urandom_range(1, 300));
    return oaht_pkg::KEY_W'($urandom);
  endfunction

  task automatic add_req(input logic [oaht_pkg::OP_W-1:0] op,
                         input logic [oaht_pkg::KEY_W-1:0] k);
    request_t r;
    r.op = op;
    r.key = k;
    req_backlog.push_back(r);
    n_sent++;
  endtask

  task automatic reg_write(input logic idx, input logic [oaht_pkg::DATA_W-1:0] val);
    if (idx == oaht_pkg::REG_PROBE_MODE) quad_mode = val[0];
    else size_reg = val[7:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_done != n_sent) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin : drive
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = req_backlog.pop_front();
        in_valid <= 1'b1;
        opcode   <= nxt.op;
        key      <= nxt.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : watch
    reply_t          want;
    reply_t          got;
    int unsigned     probes;
    cycle_cnt++;
    in_took <= in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (reply_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d slot %0d", status, slot_address);
        mismatches++;
      end else begin
        want = reply_due.pop_front();
        n_done++;
        if (status !== want.status || slot_address !== want.slot) begin
          if (mismatches < 10)
            $display("mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                     want.status, status, want.slot, slot_address);
          mismatches++;
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      hash_request(opcode, key, got.status, got.slot, probes);
      reply_due.push_back(got);
      cycle_limit += 1000 + 8 * probes;
    end
    if (cycle_cnt > cycle_limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [oaht_pkg::DATA_W-1:0] cfg_word;
    logic [7:0]                  sz;
    logic [oaht_pkg::KEY_W-1:0]  k;
    bit                          big;
    int                          r;
    int                          j;
    int                          pool_n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quad_mode = 0;
    size_reg = 8'd128;
    send_gap_pct = 25;
    recv_stall_pct = 82;
    n_sent = 0;
    n_random = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    add_req(oaht_pkg::OP_INSERT, 31'h7FFF_FFFF);
    add_req(oaht_pkg::OP_INSERT, 31'd1);
    add_req(oaht_pkg::OP_INSERT, 31'd129);
    add_req(oaht_pkg::OP_INSERT, 31'd129);
    add_req(oaht_pkg::OP_FIND, 31'd129);
    add_req(oaht_pkg::OP_DELETE, 31'd1);
    add_req(oaht_pkg::OP_FIND, 31'd129);
    add_req(oaht_pkg::OP_INSERT, 31'd129);
    add_req(oaht_pkg::OP_DELETE, 31'd129);
    add_req(oaht_pkg::OP_FIND, 31'd129);
    add_req(oaht_pkg::OP_INSERT, 31'd0);
    add_req(oaht_pkg::OP_FIND, 31'd0);
    add_req(oaht_pkg::OP_DELETE, 31'd0);
    add_req(oaht_pkg::OP_NONE, 31'd129);
    add_req(oaht_pkg::OP_DELETE, 31'd5);
    add_req(oaht_pkg::OP_FIND, 31'h4000_0000);
    add_req(oaht_pkg::OP_INSERT, 31'd127);
    wait_drained();

    reg_write(oaht_pkg::REG_TABLE_SIZE, 32'h0);
    reg_write(oaht_pkg::REG_PROBE_MODE, 32'hFFFF_FFFF);
    @(posedge clk);
    add_req(oaht_pkg::OP_INSERT, 31'd7);
    add_req(oaht_pkg::OP_FIND, 31'd127);
    add_req(oaht_pkg::OP_INSERT, 31'd127);
    wait_drained();

    reg_write(oaht_pkg::REG_TABLE_SIZE, 32'hFF);
    @(posedge clk);
    add_req(oaht_pkg::OP_FIND, 31'h7FFF_FFFF);
    add_req(oaht_pkg::OP_INSERT, 31'd255);
    add_req(oaht_pkg::OP_FIND, 31'd1);
    add_req(oaht_pkg::OP_DELETE, 31'h7FFF_FFFF);

    while (n_random < 1900) begin
      wait_drained();
      big = ($urandom_range(99) < 15);
      if (big) begin
        case ($urandom_range(3))
          0: sz = 8'd128;
          1: sz = 8'd255;
          2: sz = 8'($urandom_range(129, 254));
          default: sz = 8'($urandom_range(96, 127));
        endcase
      end else if ($urandom_range(19) == 0) begin
        sz = 8'd0;
      end else begin
        sz = ($urandom_range(9) < 7) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(9, 16));
      end
      cfg_word = $urandom_range(1) ? $urandom : 32'h0;
      cfg_word[0] = 1'($urandom_range(1));
      reg_write(oaht_pkg::REG_PROBE_MODE, cfg_word);
      cfg_word = $urandom_range(1) ? $urandom : 32'h0;
      cfg_word[7:0] = sz;
      reg_write(oaht_pkg::REG_TABLE_SIZE, cfg_word);
      @(posedge clk);
      if (n_random < 633) begin
        send_gap_pct = 25;
        recv_stall_pct = 82;
      end else if (n_random < 1266) begin
        send_gap_pct = 82;
        recv_stall_pct = 25;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      key_pool.delete();
      if (big) begin
        for (j = 0; j < 16; j++) begin
          r = $urandom_range(99);
          if (r < 45 || key_pool.size() == 0) begin
            k = rand_key();
            key_pool.push_back(k);
            add_req(oaht_pkg::OP_INSERT, k);
          end else if (r < 65) begin
            add_req(oaht_pkg::OP_FIND, key_pool[$urandom_range(key_pool.size() - 1)]);
          end else if (r < 80) begin
            add_req(oaht_pkg::OP_DELETE, key_pool[$urandom_range(key_pool.size() - 1)]);
          end else if (r < 90) begin
            add_req(oaht_pkg::OP_INSERT, key_pool[$urandom_range(key_pool.size() - 1)]);
          end else begin
            add_req(oaht_pkg::OP_FIND, rand_key());
          end
          n_random++;
        end
      end else begin
        pool_n = ((sz == 8'd0) ? 1 : int'(sz)) + int'($urandom_range(1, 4));
        for (j = 0; j < pool_n; j++) key_pool.push_back(rand_key());
        for (j = 0; j < 70; j++) begin
          r = $urandom_range(99);
          k = ($urandom_range(19) == 0) ? rand_key()
                                        : key_pool[$urandom_range(key_pool.size() - 1)];
          if (r < 40) begin
            add_req(oaht_pkg::OP_INSERT, k);
            n_random++;
          end else if (r < 68) begin
            add_req(oaht_pkg::OP_FIND, k);
            n_random++;
          end else if (r < 94) begin
            add_req(oaht_pkg::OP_DELETE, k);
            n_random++;
          end else if (r < 97) begin
            add_req(oaht_pkg::OP_NONE, k);
          end else begin
            add_req(oaht_pkg::OP_W'($urandom_range(2)), '0);
          end
        end
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && reply_due.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
